// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/sm83_pkg.sv -----
// Shared types and constants for the SM83 subset core.
`timescale 1ns / 1ps
package sm83_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [7:0] OP_HALT = 8'h76;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBC = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    localparam logic [2:0] R_HL_IND = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP_WAIT,
        ST_DECODE,
        ST_IMM1_WAIT,
        ST_IMM1,
        ST_IMM2_WAIT,
        ST_IMM2,
        ST_MEM_WAIT,
        ST_MEM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        halt;
    } t_regs;

    typedef struct packed {
        logic [7:0] res;
        logic [3:0] f;
        logic       wr_a;
    } t_alu_out;

    function automatic t_alu_out alu_op(logic [2:0] op, logic [7:0] a,
                                        logic [7:0] b, logic [3:0] fin);
        t_alu_out o;
        logic c;
        logic [8:0] s;
        logic [4:0] h;
        begin
            o.f = 4'd0;
            o.wr_a = (op != ALU_CP);
            c = 1'b0;
            s = 9'd0;
            h = 5'd0;
            case (op)
                ALU_ADD, ALU_ADC: begin
                    c = (op == ALU_ADC) & fin[0];
                    s = {1'b0, a} + {1'b0, b} + {8'd0, c};
                    h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
                    o.f[1] = h[4];
                    o.f[0] = s[8];
                end
                ALU_SUB, ALU_SBC, ALU_CP: begin
                    c = (op == ALU_SBC) & fin[0];
                    s = {1'b0, a} - {1'b0, b} - {8'd0, c};
                    h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
                    o.f[2] = 1'b1;
                    o.f[1] = h[4];
                    o.f[0] = s[8];
                end
                ALU_AND: begin
                    s = {1'b0, a & b};
                    o.f[1] = 1'b1;
                end
                ALU_XOR: s = {1'b0, a ^ b};
                default: s = {1'b0, a | b};
            endcase
            o.res = s[7:0];
            o.f[3] = (s[7:0] == 8'd0);
            return o;
        end
    endfunction
endpackage

// ----- sv/sm83_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module sm83_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/sm83_instruction_execute.sv -----
// SM83 subset core: sequencer, register file and byte memory.
// Each request is one memory write or read (through ST_MEM_WAIT, ST_MEM and
// ST_OUT), an unused command (straight to ST_OUT) or one instruction (opcode
// fetch, up to two immediate bytes, memory step, output step). The single
// memory port with registered read serves opcode fetch, immediate fetch, data
// read and write in turn. A finished result sits in the output register while the
// next request is taken; a stalled result holds the core in its output step.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sm83_instruction_execute #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cmd[1:0], mem_addr[17:2], wr_data[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata  // rd_data, reg_a, flag_bits, reg_bc, reg_de,
                                       // reg_hl, reg_sp, reg_pc, halted
);
    import sm83_pkg::*;
    localparam int AW = $clog2(MEM_BYTES);

    t_state r_state, n_state;
    t_regs r_regs, n_regs;
    logic [7:0] r_op, n_op, r_imm, n_imm, r_rd, n_rd;
    logic [1:0] r_cmd, n_cmd;
    logic [15:0] r_addr, n_addr;
    logic [7:0] r_wd, n_wd;
    logic r_ovalid, n_ovalid;
    logic [103:0] r_odata, n_odata;

    logic mem_we;
    logic [15:0] mem_a;
    logic [7:0] mem_wd, mem_rd;

    sm83_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_a[AW-1:0]),
        .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    logic acc;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    function automatic logic [7:0] get_r(t_regs g, logic [2:0] i, logic [7:0] m);
        case (i)
            3'd0: return g.bc[15:8];
            3'd1: return g.bc[7:0];
            3'd2: return g.de[15:8];
            3'd3: return g.de[7:0];
            3'd4: return g.hl[15:8];
            3'd5: return g.hl[7:0];
            3'd6: return m;
            default: return g.a;
        endcase
    endfunction

    function automatic t_regs set_r(t_regs g, logic [2:0] i, logic [7:0] v);
        t_regs o;
        o = g;
        case (i)
            3'd0: o.bc[15:8] = v;
            3'd1: o.bc[7:0] = v;
            3'd2: o.de[15:8] = v;
            3'd3: o.de[7:0] = v;
            3'd4: o.hl[15:8] = v;
            3'd5: o.hl[7:0] = v;
            3'd7: o.a = v;
            default: o = g;
        endcase
        return o;
    endfunction

    function automatic logic [15:0] get_p(t_regs g, logic [1:0] p);
        case (p)
            2'd0: return g.bc;
            2'd1: return g.de;
            2'd2: return g.hl;
            default: return g.sp;
        endcase
    endfunction

    function automatic t_regs set_p(t_regs g, logic [1:0] p, logic [15:0] v);
        t_regs o;
        o = g;
        case (p)
            2'd0: o.bc = v;
            2'd1: o.de = v;
            2'd2: o.hl = v;
            default: o.sp = v;
        endcase
        return o;
    endfunction

    // instruction classes; the opcode is decoded straight from memory in ST_DECODE
    logic [7:0] op;
    logic [2:0] rr, rs;
    logic [1:0] pp;
    logic is_mov, is_alu, is_alui, is_ld16, is_ind, is_inc16, is_dec16, is_addhl;
    logic is_inc8, is_dec8, is_ld8;
    assign op = (r_state == ST_DECODE) ? mem_rd : r_op;
    assign rr = op[5:3];
    assign rs = op[2:0];
    assign pp = op[5:4];
    always_comb begin
        is_mov = (op[7:6] == 2'b01) && (op != OP_HALT);
        is_alu = (op[7:6] == 2'b10);
        is_alui = (op[7:6] == 2'b11) && (op[2:0] == 3'd6);
        is_ld16 = (op[7:6] == 2'b00) && (op[3:0] == 4'h1);
        is_ind = (op[7:6] == 2'b00) && (op[2:0] == 3'd2);
        is_inc16 = (op[7:6] == 2'b00) && (op[3:0] == 4'h3);
        is_dec16 = (op[7:6] == 2'b00) && (op[3:0] == 4'hB);
        is_addhl = (op[7:6] == 2'b00) && (op[3:0] == 4'h9);
        is_inc8 = (op[7:6] == 2'b00) && (op[2:0] == 3'd4);
        is_dec8 = (op[7:6] == 2'b00) && (op[2:0] == 3'd5);
        is_ld8 = (op[7:6] == 2'b00) && (op[2:0] == 3'd6);
    end

    logic [15:0] ind_addr;
    assign ind_addr = (pp == 2'd0) ? r_regs.bc : (pp == 2'd1) ? r_regs.de : r_regs.hl;

    // data-path work, applied to the registers and memory in ST_MEM
    t_regs ex_regs;
    logic ex_we;
    logic [15:0] ex_wa;
    logic [7:0] ex_wd;
    always_comb begin
        t_alu_out ao;
        logic [7:0] v;
        logic [16:0] s16;
        logic [12:0] h12;
        logic [15:0] pv;
        ex_regs = r_regs;
        ex_we = 1'b0;
        ex_wa = r_regs.hl;
        ex_wd = 8'd0;
        v = 8'd0;
        pv = get_p(r_regs, pp);
        s16 = {1'b0, r_regs.hl} + {1'b0, pv};
        h12 = {1'b0, r_regs.hl[11:0]} + {1'b0, pv[11:0]};
        ao = alu_op(rr, r_regs.a, is_alui ? r_imm : get_r(r_regs, rs, mem_rd), r_regs.f);
        if (is_mov) begin
            v = get_r(r_regs, rs, mem_rd);
            ex_regs = set_r(r_regs, rr, v);
            ex_we = (rr == R_HL_IND);
            ex_wd = v;
        end else if (is_alu || is_alui) begin
            ex_regs.f = ao.f;
            if (ao.wr_a) ex_regs.a = ao.res;
        end else if (is_ld16) begin
            ex_regs = set_p(r_regs, pp, {mem_rd, r_imm});
        end else if (is_ind) begin
            ex_wa = ind_addr;
            if (op[3]) ex_regs.a = mem_rd;
            else begin
                ex_we = 1'b1;
                ex_wd = r_regs.a;
            end
            if (pp == 2'd2) ex_regs.hl = r_regs.hl + 16'd1;
            if (pp == 2'd3) ex_regs.hl = r_regs.hl - 16'd1;
        end else if (is_inc16) begin
            ex_regs = set_p(r_regs, pp, pv + 16'd1);
        end else if (is_dec16) begin
            ex_regs = set_p(r_regs, pp, pv - 16'd1);
        end else if (is_addhl) begin
            ex_regs.hl = s16[15:0];
            ex_regs.f = {r_regs.f[3], 1'b0, h12[12], s16[16]};
        end else if (is_inc8 || is_dec8) begin
            v = is_inc8 ? get_r(r_regs, rr, mem_rd) + 8'd1
                        : get_r(r_regs, rr, mem_rd) - 8'd1;
            ex_regs = set_r(r_regs, rr, v);
            ex_we = (rr == R_HL_IND);
            ex_wd = v;
            ex_regs.f = {v == 8'd0, is_dec8,
                         is_inc8 ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF), r_regs.f[0]};
        end else if (is_ld8) begin
            ex_regs = set_r(r_regs, rr, r_imm);
            ex_we = (rr == R_HL_IND);
            ex_wd = r_imm;
        end else if (op == OP_HALT) begin
            ex_regs.halt = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    unique case (s_axis_tdata[1:0])
                        CMD_WRITE, CMD_READ: n_state = ST_MEM_WAIT;
                        CMD_EXEC: n_state = ST_OP_WAIT;
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_OP_WAIT: n_state = ST_DECODE;
            ST_DECODE: n_state = (is_ld16 | is_alui | is_ld8) ? ST_IMM1_WAIT : ST_MEM_WAIT;
            ST_IMM1_WAIT: n_state = ST_IMM1;
            ST_IMM1: n_state = is_ld16 ? ST_IMM2_WAIT : ST_MEM;
            ST_IMM2_WAIT: n_state = ST_IMM2;
            ST_IMM2: n_state = ST_MEM;
            ST_MEM_WAIT: n_state = ST_MEM;
            ST_MEM: n_state = ST_OUT;
            ST_OUT: n_state = (!r_ovalid || m_axis_tready) ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and data
    always_comb begin
        n_regs = r_regs;
        n_op = r_op;
        n_imm = r_imm;
        n_rd = r_rd;
        n_cmd = r_cmd;
        n_addr = r_addr;
        n_wd = r_wd;
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_odata = r_odata;
        mem_we = 1'b0;
        mem_a = r_regs.pc + 16'd1;
        mem_wd = r_wd;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_cmd = s_axis_tdata[1:0];
                    n_addr = s_axis_tdata[17:2];
                    n_wd = s_axis_tdata[25:18];
                    n_rd = 8'd0;
                    if (s_axis_tdata[1:0] == CMD_EXEC) n_regs.pc = r_regs.pc + 16'd1;
                end
            end
            ST_OP_WAIT: mem_a = r_regs.pc;
            ST_DECODE: begin
                n_op = mem_rd;
                mem_a = r_regs.pc + 16'd1;
            end
            ST_IMM1_WAIT: begin
                n_regs.pc = r_regs.pc + 16'd1;
                mem_a = r_regs.pc + 16'd1;
            end
            ST_IMM1: begin
                n_imm = mem_rd;
                mem_a = r_regs.pc + 16'd1;
            end
            ST_IMM2_WAIT: begin
                n_regs.pc = r_regs.pc + 16'd1;
                mem_a = r_regs.pc + 16'd1;
            end
            ST_IMM2: mem_a = r_regs.pc;
            ST_MEM_WAIT: begin
                if (r_cmd == CMD_EXEC) mem_a = is_ind ? ind_addr : r_regs.hl;
                else begin
                    mem_a = r_addr;
                    mem_we = (r_cmd == CMD_WRITE);
                end
            end
            ST_MEM: begin
                if (r_cmd == CMD_EXEC) begin
                    n_regs = ex_regs;
                    mem_we = ex_we;
                    mem_a = ex_wa;
                    mem_wd = ex_wd;
                end else if (r_cmd == CMD_READ) begin
                    n_rd = mem_rd;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {3'd0, r_regs.halt, r_regs.pc, r_regs.sp, r_regs.hl,
                               r_regs.de, r_regs.bc, r_regs.f, r_regs.a, r_rd};
                end
            end
            default: n_ovalid = r_ovalid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_regs <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_regs <= n_regs;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op;
        r_imm <= n_imm;
        r_rd <= n_rd;
        r_cmd <= n_cmd;
        r_addr <= n_addr;
        r_wd <= n_wd;
        r_odata <= n_odata;
    end

    `ASSERT_IMPL(a_halt_sticky, i_clk, i_rst_n, r_regs.halt, n_regs.halt, "halt cleared")
    `ASSERT_NEXT(a_out_after_mem, i_clk, i_rst_n, r_state == ST_MEM, r_state == ST_OUT,
                 "result not formed after memory step")
    `ASSERT_IMPL(a_idle_only_accept, i_clk, i_rst_n, acc, r_state == ST_IDLE,
                 "request taken while busy")
endmodule
